### rtl/tls_pkg.sv
package tls_pkg;

    // opcodes carried on the input tuser
    localparam logic [1:0] OP_LOAD_DIAG = 2'd0;
    localparam logic [1:0] OP_LOAD_SUB  = 2'd1;
    localparam logic [1:0] OP_LOAD_RHS  = 2'd2;
    localparam logic [1:0] OP_SOLVE     = 2'd3;

    // regions of the shared store
    localparam logic [2:0] RG_DIAG = 3'd0;
    localparam logic [2:0] RG_SUB  = 3'd1;
    localparam logic [2:0] RG_RHS  = 3'd2;
    localparam logic [2:0] RG_INV  = 3'd3;
    localparam logic [2:0] RG_FSUB = 3'd4;

    // status codes on the output tuser
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    // flag bits
    localparam int FL_ZERO = 0;
    localparam int FL_SAT  = 1;

    localparam int FRAC_BITS = 16;
    localparam int DIGIT_BITS = 16;

    // handshake from an arithmetic unit back to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
        logic sat;
    } t_unit_stat;

endpackage

### rtl/tls_ram.sv
module tls_ram #(
    parameter int DW    = 32,
    parameter int ABITS = 9,
    parameter int DEPTH = 320
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [DW-1:0]    i_wdata,
    input  logic             i_re,
    input  logic [ABITS-1:0] i_raddr,
    output logic [DW-1:0]    o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // one write and one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tls_mul.sv
module tls_mul import tls_pkg::*; #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_res,
    output t_unit_stat          o_stat
);

    localparam int ND = (W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int KW = $clog2(ND + 1);
    localparam int PW = W + DIGIT_BITS;
    localparam int AW2 = 2 * W;
    localparam int MW = 2 * W + 1 - FRAC_BITS;

    logic                   r_busy;
    logic [KW-1:0]          r_k;
    logic [W-1:0]           r_ma;
    logic [ND*DIGIT_BITS-1:0] r_mb;
    logic                   r_neg;
    logic [AW2-1:0]         r_acc;
    logic [W-1:0]           r_res;
    logic                   r_done;
    logic                   r_sat;

    logic [W-1:0]   w_ua;
    logic [W-1:0]   w_ub;
    logic [PW-1:0]  w_p;
    logic [AW2-1:0] w_term;
    logic [AW2:0]   w_sum;
    logic [MW-1:0]  w_mag;
    logic [MW-1:0]  w_lim;
    logic           w_ovf;
    logic [W-1:0]   w_magc;

    // magnitudes of the operands
    assign w_ua = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_ub = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    // one 16-bit digit of b per cycle
    assign w_p    = PW'(r_ma) * PW'(r_mb[DIGIT_BITS-1:0]);
    assign w_term = AW2'(w_p) << (DIGIT_BITS * r_k);

    // round half away from zero on the magnitude, then clamp
    assign w_sum  = {1'b0, r_acc} + (AW2 + 1)'(1 << (FRAC_BITS - 1));
    assign w_mag  = w_sum[AW2:FRAC_BITS];
    assign w_lim  = r_neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    assign w_ovf  = w_mag > w_lim;
    assign w_magc = w_ovf ? W'(w_lim) : W'(w_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_ma   <= w_ua;
                r_mb   <= (ND*DIGIT_BITS)'(w_ub);
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_k != KW'(ND)) begin
                    r_acc <= r_acc + w_term;
                    r_mb  <= r_mb >> DIGIT_BITS;
                    r_k   <= r_k + 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sat  <= w_ovf;
                    r_res  <= r_neg ? (~w_magc + 1'b1) : w_magc;
                end
            end
        end
    end

    assign o_res       = r_res;
    assign o_stat.done = r_done;
    assign o_stat.zero = 1'b0;
    assign o_stat.sat  = r_sat;

endmodule

### rtl/tls_div.sv
module tls_div import tls_pkg::*; #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_d,
    output logic signed [W-1:0] o_res,
    output t_unit_stat          o_stat
);

    // numerator 2^32 + |d|/2 needs this many bits
    localparam int NW = (W > 33) ? W + 1 : 34;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_ud;
    logic          r_neg;
    logic [W-1:0]  r_res;
    logic          r_done;
    logic          r_zero;
    logic          r_sat;

    logic [W-1:0]  w_ud;
    logic [W:0]    w_rsh;
    logic          w_ge;
    logic [NW-1:0] w_lim;
    logic          w_ovf;
    logic [W-1:0]  w_magc;

    assign w_ud  = i_d[W-1] ? (~i_d + 1'b1) : i_d;

    // restoring division, one quotient bit per cycle
    assign w_rsh = {r_rem, r_num[NW-1]};
    assign w_ge  = w_rsh >= {1'b0, r_ud};

    assign w_lim  = r_neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
    assign w_ovf  = r_num > w_lim;
    assign w_magc = w_ovf ? W'(w_lim) : W'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_d == '0) begin
                    // zero pivot: inverse taken as zero
                    r_done <= 1'b1;
                    r_zero <= 1'b1;
                    r_sat  <= 1'b0;
                    r_res  <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_num  <= (NW'(1) << (2 * FRAC_BITS)) + NW'(w_ud >> 1);
                    r_rem  <= '0;
                    r_ud   <= w_ud;
                    r_neg  <= i_d[W-1];
                end
            end else if (r_busy) begin
                if (r_cnt != CW'(NW)) begin
                    r_rem <= w_ge ? W'(w_rsh - {1'b0, r_ud}) : W'(w_rsh);
                    r_num <= {r_num[NW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_zero <= 1'b0;
                    r_sat  <= w_ovf;
                    r_res  <= r_neg ? (~w_magc + 1'b1) : w_magc;
                end
            end
        end
    end

    assign o_res       = r_res;
    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;
    assign o_stat.sat  = r_sat;

endmodule

### rtl/tridiagonal_ldlt_solver.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser opcode, tdata index + value
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser status, tdata index + value, tlast
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_data = size_in_use
//
// Load requests are accepted back to back.
// A solve walks one shared store: per row, factoring costs one reciprocal
// from the bit-serial divider and three multiplies, the forward and back
// passes two and one multiplies per row, and the emit pass a store read and
// an output load per entry.
// Reset clears control state; store contents are undefined until loaded.
// A stalled output only holds the emit pass; loads still wait for the solve.
module tridiagonal_ldlt_solver import tls_pkg::*; #(
    parameter int MAX_ORDER   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // entry_index[5:0], entry_value[37:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // solution_index[5:0], solution_value[37:6], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int MA = AW + 3;
    localparam int DEPTH = 5 * (2 ** AW);
    localparam int RST_N = (MAX_ORDER < 32) ? MAX_ORDER : 32;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_F_RD_D0 = 5'd1;
    localparam logic [4:0] ST_F_LD_D0 = 5'd2;
    localparam logic [4:0] ST_F_RD_S  = 5'd3;
    localparam logic [4:0] ST_F_LD_S  = 5'd4;
    localparam logic [4:0] ST_F_DIV   = 5'd5;
    localparam logic [4:0] ST_F_MUL1  = 5'd6;
    localparam logic [4:0] ST_F_MUL2  = 5'd7;
    localparam logic [4:0] ST_F_MUL3  = 5'd8;
    localparam logic [4:0] ST_F_LAST  = 5'd9;
    localparam logic [4:0] ST_S_RD0   = 5'd10;
    localparam logic [4:0] ST_S_LD0   = 5'd11;
    localparam logic [4:0] ST_W_RD_FS = 5'd12;
    localparam logic [4:0] ST_W_LD_FS = 5'd13;
    localparam logic [4:0] ST_W_MUL1  = 5'd14;
    localparam logic [4:0] ST_W_LD_IV = 5'd15;
    localparam logic [4:0] ST_W_MUL2  = 5'd16;
    localparam logic [4:0] ST_W_LD_IL = 5'd17;
    localparam logic [4:0] ST_W_MULL  = 5'd18;
    localparam logic [4:0] ST_B_RD_FS = 5'd19;
    localparam logic [4:0] ST_B_LD_FS = 5'd20;
    localparam logic [4:0] ST_B_MUL   = 5'd21;
    localparam logic [4:0] ST_E_RD    = 5'd22;
    localparam logic [4:0] ST_E_LD    = 5'd23;

    function automatic logic [MA-1:0] maddr(logic [2:0] rg, logic [CW-1:0] idx);
        maddr = {rg, idx[AW-1:0]};
    endfunction

    // clamp to the 32-bit output range, flag in the top bit
    function automatic logic [32:0] clamp32(logic [W-1:0] x);
        logic signed [63:0] v;
        v = 64'(signed'(x));
        if (v > 64'sd2147483647) begin
            clamp32 = {1'b1, 32'h7fffffff};
        end else if (v < -64'sd2147483648) begin
            clamp32 = {1'b1, 32'h80000000};
        end else begin
            clamp32 = {1'b0, v[31:0]};
        end
    endfunction

    // clamp a load value to the working width, no flag
    function automatic logic [W-1:0] clampw(logic [31:0] x);
        logic signed [63:0] v;
        logic signed [63:0] lim;
        v   = 64'(signed'(x));
        lim = (64'sd1 <<< (W - 1)) - 64'sd1;
        if (v > lim) begin
            v = lim;
        end else if (v < -lim - 64'sd1) begin
            v = -lim - 64'sd1;
        end
        clampw = v[W-1:0];
    endfunction

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n;
    logic          r_fac_valid;
    logic [1:0]    r_fac_flags;
    logic [1:0]    r_run_flags;
    logic [W-1:0]  r_wd, r_s, r_inv, r_yprev, r_ycur, r_xnext;
    logic          r_out_valid;
    logic [5:0]    r_out_idx;
    logic [31:0]   r_out_val;
    logic          r_out_last;
    logic [1:0]    r_out_stat;

    logic          w_re, w_we;
    logic [MA-1:0] w_raddr, w_waddr;
    logic [W-1:0]  w_wdata;
    logic [W-1:0]  r_rdata;
    logic          w_mul_start, w_div_start;
    logic [W-1:0]  w_mul_a, w_mul_b, w_div_d;
    logic [W-1:0]  w_mres, w_dres;
    t_unit_stat    w_mstat, w_dstat;
    logic [W:0]    w_diff;
    logic          w_sub_ovf;
    logic [W-1:0]  w_sub;
    logic [1:0]    w_flag_set;
    logic [1:0]    w_flags_all;
    logic [1:0]    w_status;
    logic [32:0]   w_oc;
    logic [32:0]   w_mc;
    logic [32:0]   w_sc;
    logic          w_in_acc, w_cfg_acc, w_out_load;
    logic [CW-1:0] w_im1, w_ip1, w_nm1;
    logic [1:0]    w_op;
    logic [5:0]    w_idx;
    logic [6:0]    w_cfg_n;

    assign w_op  = s_axis_tuser;
    assign w_idx = s_axis_tdata[5:0];
    assign w_im1 = r_i - 1'b1;
    assign w_ip1 = r_i + 1'b1;
    assign w_nm1 = r_n - 1'b1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;

    // order clamped to the supported range
    assign w_cfg_n = (i_cfg_data < 7'd2) ? 7'd2 :
                     ((i_cfg_data > 7'(MAX_ORDER)) ? 7'(MAX_ORDER) : i_cfg_data);

    // saturating subtract: read data minus the product
    assign w_diff    = {r_rdata[W-1], r_rdata} - {w_mres[W-1], w_mres};
    assign w_sub_ovf = w_diff[W] ^ w_diff[W-1];
    assign w_sub     = w_sub_ovf ? (w_diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                                 : w_diff[W-1:0];

    assign w_flags_all = r_fac_flags | r_run_flags;
    assign w_status    = w_flags_all[FL_ZERO] ? STAT_ZERO :
                         (w_flags_all[FL_SAT] ? STAT_SAT : STAT_OK);
    assign w_oc        = clamp32(r_rdata);
    assign w_mc        = clamp32(w_mres);
    assign w_sc        = clamp32(w_sub);
    assign w_out_load  = (r_state == ST_E_LD) && (!r_out_valid || m_axis_tready);

    tls_ram #(.DW(W), .ABITS(MA), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (r_rdata)
    );

    tls_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_res   (w_mres),
        .o_stat  (w_mstat)
    );

    tls_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_d     (w_div_d),
        .o_res   (w_dres),
        .o_stat  (w_dstat)
    );

    // sequencer: store accesses, unit starts and next state
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        w_re        = 1'b0;
        w_raddr     = '0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = w_mres;
        w_mul_start = 1'b0;
        w_mul_a     = r_s;
        w_mul_b     = r_s;
        w_div_start = 1'b0;
        w_div_d     = r_wd;
        w_flag_set  = '0;
        if (w_mstat.done) begin
            w_flag_set[FL_SAT] = w_mstat.sat;
        end
        if (w_dstat.done) begin
            w_flag_set[FL_SAT]  = w_dstat.sat;
            w_flag_set[FL_ZERO] = w_dstat.zero;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_op == OP_SOLVE) begin
                        n_state = r_fac_valid ? ST_S_RD0 : ST_F_RD_D0;
                    end else if ({1'b0, w_idx} < 7'(MAX_ORDER)) begin
                        w_we    = 1'b1;
                        w_wdata = clampw(s_axis_tdata[37:6]);
                        case (w_op)
                            OP_LOAD_DIAG: w_waddr = {RG_DIAG, w_idx[AW-1:0]};
                            OP_LOAD_SUB:  w_waddr = {RG_SUB, w_idx[AW-1:0]};
                            default:      w_waddr = {RG_RHS, w_idx[AW-1:0]};
                        endcase
                    end
                end
            end
            ST_F_RD_D0: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_DIAG, '0);
                n_i     = '0;
                n_state = ST_F_LD_D0;
            end
            ST_F_LD_D0: n_state = ST_F_RD_S;
            ST_F_RD_S: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_SUB, r_i);
                n_state = ST_F_LD_S;
            end
            ST_F_LD_S: begin
                w_div_start = 1'b1;
                n_state     = ST_F_DIV;
            end
            ST_F_DIV: begin
                if (w_dstat.done) begin
                    w_we        = 1'b1;
                    w_waddr     = maddr(RG_INV, r_i);
                    w_wdata     = w_dres;
                    w_mul_start = 1'b1;
                    n_state     = ST_F_MUL1;
                end
            end
            ST_F_MUL1: begin
                if (w_mstat.done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = w_mres;
                    w_mul_b     = r_inv;
                    w_re        = 1'b1;
                    w_raddr     = maddr(RG_DIAG, w_ip1);
                    n_state     = ST_F_MUL2;
                end
            end
            ST_F_MUL2: begin
                if (w_mstat.done) begin
                    w_flag_set[FL_SAT] = w_mstat.sat | w_sub_ovf;
                    w_mul_start = 1'b1;
                    w_mul_b     = r_inv;
                    n_state     = ST_F_MUL3;
                end
            end
            ST_F_MUL3: begin
                if (w_mstat.done) begin
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_FSUB, r_i);
                    if (CW'(r_i + 2'd2) < r_n) begin
                        n_i     = w_ip1;
                        n_state = ST_F_RD_S;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = ST_F_LAST;
                    end
                end
            end
            ST_F_LAST: begin
                if (w_dstat.done) begin
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_INV, w_nm1);
                    w_wdata = w_dres;
                    n_state = ST_S_RD0;
                end
            end
            ST_S_RD0: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_RHS, '0);
                n_i     = CW'(1);
                n_state = ST_S_LD0;
            end
            ST_S_LD0: n_state = ST_W_RD_FS;
            ST_W_RD_FS: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_FSUB, w_im1);
                n_state = ST_W_LD_FS;
            end
            ST_W_LD_FS: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_rdata;
                w_mul_b     = r_yprev;
                w_re        = 1'b1;
                w_raddr     = maddr(RG_RHS, r_i);
                n_state     = ST_W_MUL1;
            end
            ST_W_MUL1: begin
                if (w_mstat.done) begin
                    w_flag_set[FL_SAT] = w_mstat.sat | w_sub_ovf;
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_RHS, r_i);
                    w_wdata = w_sub;
                    w_re    = 1'b1;
                    w_raddr = maddr(RG_INV, w_im1);
                    n_state = ST_W_LD_IV;
                end
            end
            ST_W_LD_IV: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_yprev;
                w_mul_b     = r_rdata;
                n_state     = ST_W_MUL2;
            end
            ST_W_MUL2: begin
                if (w_mstat.done) begin
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_RHS, w_im1);
                    if (w_ip1 < r_n) begin
                        n_i     = w_ip1;
                        n_state = ST_W_RD_FS;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = maddr(RG_INV, r_i);
                        n_state = ST_W_LD_IL;
                    end
                end
            end
            ST_W_LD_IL: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_yprev;
                w_mul_b     = r_rdata;
                n_state     = ST_W_MULL;
            end
            ST_W_MULL: begin
                if (w_mstat.done) begin
                    w_flag_set[FL_SAT] = w_mstat.sat | w_mc[32];
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_RHS, w_nm1);
                    n_i     = CW'(r_n - 2'd2);
                    n_state = ST_B_RD_FS;
                end
            end
            ST_B_RD_FS: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_FSUB, r_i);
                n_state = ST_B_LD_FS;
            end
            ST_B_LD_FS: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_rdata;
                w_mul_b     = r_xnext;
                w_re        = 1'b1;
                w_raddr     = maddr(RG_RHS, r_i);
                n_state     = ST_B_MUL;
            end
            ST_B_MUL: begin
                if (w_mstat.done) begin
                    w_flag_set[FL_SAT] = w_mstat.sat | w_sub_ovf | w_sc[32];
                    w_we    = 1'b1;
                    w_waddr = maddr(RG_RHS, r_i);
                    w_wdata = w_sub;
                    if (r_i == '0) begin
                        n_state = ST_E_RD;
                    end else begin
                        n_i     = w_im1;
                        n_state = ST_B_RD_FS;
                    end
                end
            end
            ST_E_RD: begin
                w_re    = 1'b1;
                w_raddr = maddr(RG_RHS, r_i);
                n_state = ST_E_LD;
            end
            ST_E_LD: begin
                if (w_out_load) begin
                    if (w_ip1 == r_n) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = w_ip1;
                        n_state = ST_E_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_n         <= CW'(RST_N);
            r_fac_valid <= 1'b0;
            r_fac_flags <= '0;
            r_run_flags <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            if (w_cfg_acc) begin
                r_n         <= CW'(w_cfg_n);
                r_fac_valid <= 1'b0;
            end
            if (w_in_acc && (w_op == OP_LOAD_DIAG || w_op == OP_LOAD_SUB)
                    && {1'b0, w_idx} < 7'(MAX_ORDER)) begin
                r_fac_valid <= 1'b0;
            end
            // run flags: cleared when a factoring or a solve starts
            if (w_in_acc && w_op == OP_SOLVE) begin
                r_run_flags <= '0;
            end else if (r_state == ST_F_LAST && w_dstat.done) begin
                r_fac_flags <= r_run_flags | w_flag_set;
                r_fac_valid <= 1'b1;
            end else if (r_state == ST_S_RD0) begin
                r_run_flags <= '0;
            end else begin
                r_run_flags <= r_run_flags | w_flag_set;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working values and the output register
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_F_LD_D0: r_wd <= r_rdata;
            ST_F_LD_S:  r_s  <= r_rdata;
            ST_F_DIV:   r_inv <= w_dres;
            ST_F_MUL2:  if (w_mstat.done) r_wd <= w_sub;
            ST_S_LD0:   r_yprev <= r_rdata;
            ST_W_MUL1:  if (w_mstat.done) r_ycur <= w_sub;
            ST_W_MUL2:  if (w_mstat.done) r_yprev <= r_ycur;
            ST_W_MULL:  if (w_mstat.done) r_xnext <= w_mres;
            ST_B_MUL:   if (w_mstat.done) r_xnext <= w_sub;
            default: ;
        endcase
        if (w_out_load) begin
            r_out_idx  <= 6'(r_i);
            r_out_val  <= w_oc[31:0];
            r_out_last <= (w_ip1 == r_n);
            r_out_stat <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_val, r_out_idx};
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tlast  = r_out_last;

    // the two arithmetic units never finish together
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mstat.done && w_dstat.done))
        else $error("multiplier and divider finished in the same cycle");

    // the last entry carries index n-1
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'(w_nm1)))
        else $error("last entry index differs from order minus one");

    // idle store writes come only from accepted load requests
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && w_we) |-> (w_in_acc && w_op != OP_SOLVE))
        else $error("store written while idle without a load request");

    // a new solve never starts while a unit is still finishing
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_op == OP_SOLVE) |=> !(w_mstat.done || w_dstat.done))
        else $error("arithmetic unit finished right after a solve request");

endmodule
